// ===== sv/tmq_pkg.sv =====
// Shared request and status codes and field widths of the timed message queue.
`timescale 1ns / 1ps
`default_nettype none
package tmq_pkg;
  localparam int unsigned OP_W = 2;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned PORT_TIME_W = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned REMOVED_W = 5;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_POLL    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;
  localparam logic [OP_W-1:0] OP_QUIT    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_DUE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLOSED  = 3'd5;
endpackage
`default_nettype wire

// ===== sv/tmq_front.sv =====
// Request front end: takes input transactions, picks the relevant time and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module tmq_front
  import tmq_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [OP_W-1:0]        req_type,
  input  wire logic [HANDLE_W-1:0]    msg_handle,
  input  wire logic [TAG_W-1:0]       msg_tag,
  input  wire logic [PORT_TIME_W-1:0] due_time,
  input  wire logic [PORT_TIME_W-1:0] now_time,
  output logic                        cmd_valid,
  input  wire logic                   cmd_ready,
  output logic [OP_W-1:0]             cmd_op,
  output logic [HANDLE_W-1:0]         cmd_handle,
  output logic [TAG_W-1:0]            cmd_tag,
  output logic [TIME_BITS-1:0]        cmd_time
);
  logic [PORT_TIME_W-1:0] sel_time;
  logic [TIME_BITS-1:0]   item_time;
  logic [OP_W-1:0]        q_op     [2];
  logic [HANDLE_W-1:0]    q_handle [2];
  logic [TAG_W-1:0]       q_tag    [2];
  logic [TIME_BITS-1:0]   q_time   [2];
  logic                   wptr;
  logic                   rptr;
  logic [1:0]             fill;
  logic                   push;
  logic                   pop;

  // A poll carries the current time, every other request the due time.
  assign sel_time = (req_type == OP_POLL) ? now_time : due_time;

  generate
    if (TIME_BITS > PORT_TIME_W) begin : g_wide
      assign item_time = {{(TIME_BITS - PORT_TIME_W){1'b0}}, sel_time};
    end else begin : g_narrow
      assign item_time = sel_time[TIME_BITS-1:0];
    end
  endgenerate

  assign in_stall   = (fill == 2'd2);
  assign push       = in_valid && !in_stall;
  assign cmd_valid  = (fill != 2'd0);
  assign pop        = cmd_valid && cmd_ready;
  assign cmd_op     = q_op[rptr];
  assign cmd_handle = q_handle[rptr];
  assign cmd_tag    = q_tag[rptr];
  assign cmd_time   = q_time[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wptr]     <= req_type;
      q_handle[wptr] <= msg_handle;
      q_tag[wptr]    <= msg_tag;
      q_time[wptr]   <= item_time;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/tmq_back.sv =====
// Command engine: sorted message store, its walking sequencer and the result register.
`timescale 1ns / 1ps
`default_nettype none
module tmq_back
  import tmq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire logic [OP_W-1:0]      cmd_op,
  input  wire logic [HANDLE_W-1:0]  cmd_handle,
  input  wire logic [TAG_W-1:0]     cmd_tag,
  input  wire logic [TIME_BITS-1:0] cmd_time,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [STATUS_W-1:0]       status,
  output logic [HANDLE_W-1:0]       out_handle,
  output logic [TAG_W-1:0]          out_tag,
  output logic [PORT_TIME_W-1:0]    out_due,
  output logic [PORT_TIME_W-1:0]    wait_ms,
  output logic                      wake,
  output logic [REMOVED_W-1:0]      removed_count
);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE = CW'(1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ENQ_RD   = 3'd1;
  localparam logic [2:0] S_ENQ_CMP  = 3'd2;
  localparam logic [2:0] S_ENQ_PUT  = 3'd3;
  localparam logic [2:0] S_POLL_CMP = 3'd4;
  localparam logic [2:0] S_SHIFT_RD = 3'd5;
  localparam logic [2:0] S_SHIFT_WR = 3'd6;
  localparam logic [2:0] S_REM_CMP  = 3'd7;

  typedef struct packed {
    logic [TIME_BITS-1:0] due;
    logic [TAG_W-1:0]     tag;
    logic [HANDLE_W-1:0]  handle;
  } entry_t;

  entry_t             mem [QUEUE_DEPTH];
  entry_t             rdata;
  entry_t             new_entry;
  entry_t             wdata;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;

  logic [2:0]               state;
  logic [CW-1:0]            count;
  logic                     quit;
  logic                     blocked;
  logic [CW-1:0]            idx;
  logic [CW-1:0]            wr;
  logic [CW-1:0]            gone;
  logic [TAG_W-1:0]         c_tag;
  logic [HANDLE_W-1:0]      c_handle;
  logic [TIME_BITS-1:0]     c_time;
  logic                     take;
  logic                     rem_hit;
  logic [TIME_BITS-1:0]     diff;
  logic [PORT_TIME_W-1:0]   head_due_p;
  logic [PORT_TIME_W-1:0]   diff_p;
  logic [CW-1:0]            gone_inc;
  // Remove walks reuse the shift read step; this flag marks such a walk.
  logic                     rem_mode;

  assign cmd_ready = (state == S_IDLE) && (!out_valid || !out_stall);
  assign take      = cmd_valid && cmd_ready;
  assign rem_hit   = (rdata.tag == c_tag);
  assign diff      = rdata.due - c_time;
  assign gone_inc  = gone + ONE;

  generate
    if (TIME_BITS >= PORT_TIME_W) begin : g_wide
      assign head_due_p = rdata.due[PORT_TIME_W-1:0];
      assign diff_p     = diff[PORT_TIME_W-1:0];
    end else begin : g_narrow
      assign head_due_p = {{(PORT_TIME_W - TIME_BITS){1'b0}}, rdata.due};
      assign diff_p     = {{(PORT_TIME_W - TIME_BITS){1'b0}}, diff};
    end
  endgenerate

  always_comb begin
    new_entry.due    = c_time;
    new_entry.tag    = c_tag;
    new_entry.handle = c_handle;
    if (state == S_IDLE) begin
      new_entry.due    = cmd_time;
      new_entry.tag    = cmd_tag;
      new_entry.handle = cmd_handle;
    end
  end

  // Store port control.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    raddr = idx[AW-1:0];
    case (state)
      S_IDLE: begin
        raddr = '0;
        if (take && cmd_op == OP_ENQUEUE && !quit && count == '0) begin
          we    = 1'b1;
          wdata = new_entry;
        end
      end
      S_ENQ_CMP: begin
        we    = 1'b1;
        waddr = idx[AW-1:0] + AW'(1);
        if (rdata.due <= c_time) begin
          wdata = new_entry;
        end
      end
      S_ENQ_PUT: begin
        we    = 1'b1;
        wdata = new_entry;
      end
      S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = idx[AW-1:0] - AW'(1);
      end
      S_REM_CMP: begin
        we    = !rem_hit;
        waddr = wr[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      quit      <= 1'b0;
      blocked   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            c_tag         <= cmd_tag;
            c_handle      <= cmd_handle;
            c_time        <= cmd_time;
            status        <= ST_OK;
            out_handle    <= '0;
            out_tag       <= '0;
            out_due       <= '0;
            wait_ms       <= '0;
            wake          <= 1'b0;
            removed_count <= '0;
            case (cmd_op)
              OP_ENQUEUE: begin
                if (quit) begin
                  status    <= ST_REFUSED;
                  out_valid <= 1'b1;
                end else if (count == FULL_COUNT) begin
                  status    <= ST_FULL;
                  out_valid <= 1'b1;
                end else if (count == '0) begin
                  count     <= ONE;
                  wake      <= blocked;
                  out_valid <= 1'b1;
                end else begin
                  idx   <= count - ONE;
                  state <= S_ENQ_RD;
                end
              end
              OP_POLL: begin
                if (count == '0) begin
                  status    <= quit ? ST_CLOSED : ST_EMPTY;
                  blocked   <= blocked || !quit;
                  out_valid <= 1'b1;
                end else begin
                  state <= S_POLL_CMP;
                end
              end
              OP_REMOVE: begin
                if (count == '0) begin
                  out_valid <= 1'b1;
                end else begin
                  idx   <= '0;
                  wr    <= '0;
                  gone  <= '0;
                  state <= S_SHIFT_RD;
                end
              end
              OP_QUIT: begin
                wake      <= !quit;
                quit      <= 1'b1;
                out_valid <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_ENQ_RD: begin
          state <= S_ENQ_CMP;
        end
        S_ENQ_CMP: begin
          if (rdata.due > c_time) begin
            if (idx == '0) begin
              state <= S_ENQ_PUT;
            end else begin
              idx   <= idx - ONE;
              state <= S_ENQ_RD;
            end
          end else begin
            count     <= count + ONE;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_ENQ_PUT: begin
          count     <= count + ONE;
          wake      <= blocked;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_POLL_CMP: begin
          if (c_time >= rdata.due) begin
            out_handle <= rdata.handle;
            out_tag    <= rdata.tag;
            out_due    <= head_due_p;
            blocked    <= 1'b0;
            count      <= count - ONE;
            out_valid  <= 1'b1;
            if (count > ONE) begin
              idx   <= ONE;
              state <= S_SHIFT_RD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            if (quit) begin
              status <= ST_CLOSED;
            end else begin
              status  <= ST_NOT_DUE;
              wait_ms <= diff_p;
              blocked <= 1'b1;
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_SHIFT_RD: begin
          // A remove compares the entry just read; a pop moves it up one place.
          state <= rem_mode ? S_REM_CMP : S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (idx == count) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx + ONE;
            state <= S_SHIFT_RD;
          end
        end
        S_REM_CMP: begin
          if (rem_hit) begin
            gone <= gone_inc;
          end else begin
            wr <= wr + ONE;
          end
          if (idx == count - ONE) begin
            count         <= rem_hit ? wr : wr + ONE;
            removed_count <= rem_hit ? REMOVED_W'(gone_inc) : REMOVED_W'(gone);
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end else begin
            idx   <= idx + ONE;
            state <= S_SHIFT_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem_mode <= 1'b0;
    end else if (take) begin
      rem_mode <= (cmd_op == OP_REMOVE);
    end
  end
endmodule
`default_nettype wire

// ===== sv/timed_message_queue.sv =====
// Timed message queue: a two-entry command queue in front of a sorted-store engine.
// The command queue registers each command; quit, refused, full and every command on an
// empty store answer the cycle after the engine takes them, a poll after its compare step.
// Engine steps: a poll compares the head, then moves each remaining entry up one place;
// an enqueue walks down from the tail, moving later entries down; a remove compares each entry.
// Synchronous reset empties the store, clears quit and blocked and drops transactions.
`timescale 1ns / 1ps
`default_nettype none
module timed_message_queue
  import tmq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [OP_W-1:0]        req_type,
  input  wire logic [HANDLE_W-1:0]    msg_handle,
  input  wire logic [TAG_W-1:0]       msg_tag,
  input  wire logic [PORT_TIME_W-1:0] due_time,
  input  wire logic [PORT_TIME_W-1:0] now_time,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [STATUS_W-1:0]         status,
  output logic [HANDLE_W-1:0]         out_handle,
  output logic [TAG_W-1:0]            out_tag,
  output logic [PORT_TIME_W-1:0]      out_due,
  output logic [PORT_TIME_W-1:0]      wait_ms,
  output logic                        wake,
  output logic [REMOVED_W-1:0]        removed_count
);
  // Commands pass from the front end to the engine through a two-entry queue,
  // so input transactions are taken while the engine walks the store.
  logic                 cmd_valid;
  logic                 cmd_ready;
  logic [OP_W-1:0]      cmd_op;
  logic [HANDLE_W-1:0]  cmd_handle;
  logic [TAG_W-1:0]     cmd_tag;
  logic [TIME_BITS-1:0] cmd_time;

  tmq_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .msg_handle (msg_handle),
    .msg_tag    (msg_tag),
    .due_time   (due_time),
    .now_time   (now_time),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_op     (cmd_op),
    .cmd_handle (cmd_handle),
    .cmd_tag    (cmd_tag),
    .cmd_time   (cmd_time)
  );

  // The engine keeps the store sorted by due time and holds each result in
  // its output register until it is taken.
  tmq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd_op        (cmd_op),
    .cmd_handle    (cmd_handle),
    .cmd_tag       (cmd_tag),
    .cmd_time      (cmd_time),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .out_handle    (out_handle),
    .out_tag       (out_tag),
    .out_due       (out_due),
    .wait_ms       (wait_ms),
    .wake          (wake),
    .removed_count (removed_count)
  );
endmodule
`default_nettype wire
